/* sv/kcl_pkg.sv */
// Shared constants and types for the keypad code lock entry block.
// Key codes, event codes, register indexes and the decision word.
// No dependencies.
`default_nettype none

package kcl_pkg;

  // Number of digits in the unlock code; the top-level default
  localparam int KCL_CODE_DIGITS = 4;

  // Configuration register indexes
  localparam logic CFG_UNLOCK_CODE = 1'b0;
  localparam logic CFG_DEBOUNCE_MS = 1'b1;

  // Register reset values
  localparam logic [15:0] UNLOCK_CODE_RST = 16'h1234;
  localparam logic [7:0]  DEBOUNCE_MS_RST = 8'd60;

  // Input action codes
  localparam logic ACT_KEY     = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Mapped key codes (ASCII)
  localparam logic [7:0] KEY_WARN   = 8'h41;  // 'A'
  localparam logic [7:0] KEY_HELP   = 8'h42;  // 'B'
  localparam logic [7:0] KEY_CLEAR  = 8'h43;  // 'C'
  localparam logic [7:0] KEY_DELETE = 8'h2A;  // '*'
  localparam logic [7:0] KEY_SUBMIT = 8'h23;  // '#'
  localparam logic [7:0] KEY_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] KEY_NINE   = 8'h39;  // '9'

  // Result event kinds
  localparam logic [1:0] EV_WARN   = 2'd0;
  localparam logic [1:0] EV_HELP   = 2'd1;
  localparam logic [1:0] EV_UNLOCK = 2'd2;
  localparam logic [1:0] EV_BAD    = 2'd3;

  // What one word does to the state and the result slot
  typedef struct packed {
    logic       release_all;  // clear the wait-for-release flag
    logic       take;         // key accepted: update last key, arm wait
    logic       emit;         // produce a result word
    logic [1:0] kind;         // event kind of that result
    logic       clr;          // empty the entry buffer
    logic       del;          // drop the last digit
    logic       push;         // append key_char as a digit
  } kcl_dec_t;

endpackage

`default_nettype wire

/* sv/kcl_step.sv */
// Decision logic for one keypad word: debounce filter, key decode, code compare.
// Depends on kcl_pkg.
`default_nettype none

module kcl_step import kcl_pkg::*; #(
  parameter int CODE_DIGITS = KCL_CODE_DIGITS,
  localparam int LW = $clog2(CODE_DIGITS + 1)
) (
  input  wire logic                     action,
  input  wire logic [7:0]               key_char,
  input  wire logic [31:0]              now_ms,
  input  wire logic                     waiting_release,
  input  wire logic [7:0]               last_key,
  input  wire logic [31:0]              last_key_time,
  input  wire logic [7:0]               debounce_ms,
  input  wire logic [15:0]              unlock_code,
  input  wire logic [LW-1:0]            entry_length,
  input  wire logic [CODE_DIGITS*4-1:0] entered_digits,
  output kcl_dec_t                      dec
);

  logic [31:0] elapsed;
  logic        bounce;
  logic        match;
  logic [31:0] code_wide;

  assign elapsed   = now_ms - last_key_time;
  assign bounce    = (elapsed < {24'd0, debounce_ms}) && (key_char == last_key);
  assign code_wide = {16'd0, unlock_code};

  // Full entry and every digit equal to its nibble; when there are more
  // than four digits, the leading ones compare against zero.
  always_comb begin
    match = (entry_length == LW'(CODE_DIGITS));
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (entered_digits[4*i +: 4] != code_wide[4*(CODE_DIGITS-1-i) +: 4]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    dec             = '0;
    dec.release_all = (action == ACT_RELEASE);
    if ((action == ACT_KEY) && !waiting_release && !bounce) begin
      dec.take = 1'b1;
      case (key_char)
        KEY_WARN: begin
          dec.emit = 1'b1;
          dec.kind = EV_WARN;
        end
        KEY_HELP: begin
          dec.emit = 1'b1;
          dec.kind = EV_HELP;
        end
        KEY_CLEAR: begin
          dec.clr = 1'b1;
        end
        KEY_DELETE: begin
          dec.del = (entry_length != '0);
        end
        KEY_SUBMIT: begin
          dec.emit = 1'b1;
          dec.kind = match ? EV_UNLOCK : EV_BAD;
          dec.clr  = 1'b1;
        end
        default: begin
          if (key_char inside {[KEY_ZERO:KEY_NINE]}) begin
            dec.push = (entry_length < LW'(CODE_DIGITS));
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/keypad_code_lock_entry_top.sv */
// Keypad code lock entry: an input word goes into the input register, then through
// the decision logic into the result register, which raises out_valid when the
// word makes a result.
// Throughput one word per cycle; the only stall is a full result register
// that the sink does not take. cfg_ready is always high.
// rst_n is synchronous, active low: clears both valid flags, the key history,
// the entry length and loads the register reset values.
`default_nettype none

module keypad_code_lock_entry_top import kcl_pkg::*; #(
  parameter int CODE_DIGITS = KCL_CODE_DIGITS,
  localparam int LW = $clog2(CODE_DIGITS + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_key_char,
  input  wire logic [31:0] in_now_ms,
  // result words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [31:0]      out_event_time,
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers
  logic [15:0] unlock_code_r;
  logic [7:0]  debounce_ms_r;

  // Input register
  logic        s1_valid_r;
  logic        s1_action_r;
  logic [7:0]  s1_key_r;
  logic [31:0] s1_now_r;

  // Key history and entry buffer
  logic                     waiting_r, waiting_nxt;
  logic [7:0]               last_key_r;
  logic [31:0]              last_time_r;
  logic [LW-1:0]            len_r, len_nxt;
  logic [3:0]               digits_r [CODE_DIGITS];
  logic [CODE_DIGITS*4-1:0] digits_flat;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r;
  logic [31:0] out_time_r;

  kcl_dec_t dec;
  logic     proc;

  // The word in the input register moves on whenever the result slot is
  // free or drains this cycle; every word waits on a stalled result slot,
  // whether it makes a result or not.
  assign proc     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || proc;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_event_time = out_time_r;

  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      digits_flat[4*i +: 4] = digits_r[i];
    end
  end

  kcl_step #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_step (
    .action          (s1_action_r),
    .key_char        (s1_key_r),
    .now_ms          (s1_now_r),
    .waiting_release (waiting_r),
    .last_key        (last_key_r),
    .last_key_time   (last_time_r),
    .debounce_ms     (debounce_ms_r),
    .unlock_code     (unlock_code_r),
    .entry_length    (len_r),
    .entered_digits  (digits_flat),
    .dec             (dec)
  );

  // Next values of the control state
  always_comb begin
    waiting_nxt   = waiting_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (proc) begin
      if (dec.release_all) begin
        waiting_nxt = 1'b0;
      end
      if (dec.take) begin
        waiting_nxt = 1'b1;
      end
      if (dec.clr) begin
        len_nxt = '0;
      end else if (dec.del) begin
        len_nxt = len_r - LW'(1);
      end else if (dec.push) begin
        len_nxt = len_r + LW'(1);
      end
      out_valid_nxt = dec.emit;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unlock_code_r <= UNLOCK_CODE_RST;
      debounce_ms_r <= DEBOUNCE_MS_RST;
      s1_valid_r    <= 1'b0;
      waiting_r     <= 1'b0;
      last_key_r    <= '0;
      last_time_r   <= '0;
      len_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_UNLOCK_CODE: unlock_code_r <= cfg_data;
          CFG_DEBOUNCE_MS: debounce_ms_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      waiting_r   <= waiting_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      // remember the last accepted key and when it came
      if (proc && dec.take) begin
        last_key_r  <= s1_key_r;
        last_time_r <= s1_now_r;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_key_r    <= in_key_char;
      s1_now_r    <= in_now_ms;
    end
    if (proc && dec.emit) begin
      out_kind_r <= dec.kind;
      out_time_r <= s1_now_r;
    end
    // append the digit at the current fill position; the low nibble of an
    // ASCII digit is its value
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (proc && dec.push && (len_r == LW'(i))) begin
        digits_r[i] <= s1_key_r[3:0];
      end
    end
  end

endmodule

`default_nettype wire

/* sv/kcl_checker.sv */
// Port-level checks for the keypad code lock entry block, bound to the top level.
// Depends on keypad_code_lock_entry_top.
`default_nettype none

module kcl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_event_kind,
  input wire logic [31:0] out_event_time
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind)
                                && $stable(out_event_time))
    else $error("stalled result word changed");

  // a fresh result comes from an earlier accepted input word
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word without a matching input word");

  // input side only waits on a stalled result slot
  a_no_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input held off with a free result slot");

endmodule

bind keypad_code_lock_entry_top kcl_checker u_kcl_checker (.*);

`default_nettype wire
